### rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled during reset. Needs clk and rst_n in scope.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the next cycle.
`define ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### rtl/core/smbt_pkg.sv
`timescale 1ns / 1ps

package smbt_pkg;

    typedef enum logic [2:0] {
        MODE_LOAD_TX    = 3'd0,
        MODE_READ_RX    = 3'd1,
        MODE_START_WR   = 3'd2,
        MODE_START_RD   = 3'd3,
        MODE_START_WRRD = 3'd4,
        MODE_BYTE_DONE  = 3'd5,
        MODE_CLEAR_IDLE = 3'd6,
        MODE_DESELECT   = 3'd7
    } mode_t;

    typedef enum logic [2:0] {
        XS_IDLE      = 3'd0,
        XS_TX_BUSY   = 3'd1,
        XS_TX_DONE   = 3'd2,
        XS_RX_BUSY   = 3'd3,
        XS_RX_DONE   = 3'd4,
        XS_TXRX_BUSY = 3'd5,
        XS_TXRX_DONE = 3'd6
    } xfer_status_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_EXEC,
        CS_FETCH,
        CS_RESP
    } ctrl_state_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [3:0] slave_select;
        logic [7:0] byte_count;
        logic [5:0] buffer_index;
        logic [7:0] write_data;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic       accepted;
        logic [2:0] status;
        logic       shift_valid;
        logic [7:0] shift_byte;
        logic [3:0] slave_enables;
        logic [7:0] read_data;
    } out_item_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic fetch;
    } ctrl_cmd_t;

endpackage

### rtl/core/smbt_ram.sv
`timescale 1ns / 1ps

module smbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/smbt_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module smbt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output smbt_pkg::ctrl_cmd_t cmd
);

    import smbt_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        cmd.capture = 1'b0;
        cmd.exec    = 1'b0;
        cmd.fetch   = 1'b0;
        unique case (state_reg)
            CS_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = CS_EXEC;
                end
            end
            CS_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = CS_FETCH;
            end
            CS_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = CS_RESP;
            end
            CS_RESP:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = CS_IDLE;
                end
            end
        endcase
    end

    `ASSERT_NEXT(a_accept_execs, in_valid && in_ready, cmd.exec, "accepted item not executed")
    `ASSERT_NEXT(a_taken_frees, out_valid && out_ready, in_ready && !out_valid,
                 "result transfer did not free the block")
    `ASSERT_NEXT(a_exec_result, cmd.fetch, out_valid, "fetched result not presented")

endmodule

### rtl/core/smbt_datapath.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module smbt_datapath #(
    parameter int BUF_DEPTH   = 64,
    parameter int SLAVE_COUNT = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  smbt_pkg::ctrl_cmd_t cmd,
    input  smbt_pkg::in_item_t  in_data,
    input  logic                cfg_valid,
    input  logic [7:0]          cfg_data,
    output smbt_pkg::out_item_t out_data
);

    import smbt_pkg::*;

    localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int IW = $clog2(BUF_DEPTH + 1);
    localparam logic [7:0] DEPTH8 = 8'(BUF_DEPTH);
    localparam logic [3:0] SLAVE_MASK = 4'((1 << SLAVE_COUNT) - 1);

    in_item_t        item_reg, item_next;
    logic [7:0]      dummy_reg, dummy_next;
    xfer_status_t    status_reg, status_next;
    logic [IW-1:0]   idx_reg, idx_next;
    logic [IW-1:0]   len_reg, len_next;
    logic [3:0]      act_reg, act_next;
    logic [BUF_DEPTH-1:0] tx_vld_reg, tx_vld_next;
    logic [BUF_DEPTH-1:0] rx_vld_reg, rx_vld_next;
    logic            acc_reg, acc_next;
    logic            sv_reg, sv_next;
    logic            use_tx_reg, use_tx_next;
    logic            rd_reg, rd_next;
    logic            tx_ok_reg, tx_ok_next;
    logic            rx_ok_reg, rx_ok_next;
    out_item_t       result_reg, result_next;

    logic            tx_we, rx_we;
    logic [AW-1:0]   tx_waddr, tx_raddr, rx_waddr, rx_raddr;
    logic [7:0]      tx_rdata, rx_rdata;
    logic            bidx_ok, count_ok, busy, is_done;
    logic [3:0]      sel_bit;
    logic [7:0]      shift_byte;

    smbt_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH), .AW(AW)) u_tx_ram (
        .clk   (clk),
        .we    (tx_we),
        .waddr (tx_waddr),
        .wdata (item_reg.write_data),
        .raddr (tx_raddr),
        .rdata (tx_rdata)
    );

    smbt_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH), .AW(AW)) u_rx_ram (
        .clk   (clk),
        .we    (rx_we),
        .waddr (rx_waddr),
        .wdata (item_reg.rx_byte),
        .raddr (rx_raddr),
        .rdata (rx_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dummy_reg  <= '0;
            status_reg <= XS_IDLE;
            idx_reg    <= '0;
            len_reg    <= '0;
            act_reg    <= '0;
            tx_vld_reg <= '0;
            rx_vld_reg <= '0;
        end
        else
        begin
            dummy_reg  <= dummy_next;
            status_reg <= status_next;
            idx_reg    <= idx_next;
            len_reg    <= len_next;
            act_reg    <= act_next;
            tx_vld_reg <= tx_vld_next;
            rx_vld_reg <= rx_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        acc_reg    <= acc_next;
        sv_reg     <= sv_next;
        use_tx_reg <= use_tx_next;
        rd_reg     <= rd_next;
        tx_ok_reg  <= tx_ok_next;
        rx_ok_reg  <= rx_ok_next;
        result_reg <= result_next;
    end

    assign bidx_ok  = {2'b00, item_reg.buffer_index} < DEPTH8;
    assign count_ok = (item_reg.byte_count != 8'd0) && (item_reg.byte_count <= DEPTH8);
    assign busy     = (status_reg == XS_TX_BUSY) || (status_reg == XS_RX_BUSY)
                   || (status_reg == XS_TXRX_BUSY);
    assign is_done  = (status_reg == XS_TX_DONE) || (status_reg == XS_RX_DONE)
                   || (status_reg == XS_TXRX_DONE);
    assign sel_bit  = (item_reg.slave_select & SLAVE_MASK)
                    & (~(item_reg.slave_select & SLAVE_MASK) + 4'd1);

    assign tx_waddr = AW'(item_reg.buffer_index);
    assign rx_raddr = AW'(item_reg.buffer_index);
    assign rx_waddr = AW'(idx_reg - IW'(1));
    assign tx_raddr = (mode_t'(item_reg.mode) == MODE_BYTE_DONE) ? AW'(idx_reg) : '0;

    always_comb
    begin
        item_next   = item_reg;
        dummy_next  = dummy_reg;
        status_next = status_reg;
        idx_next    = idx_reg;
        len_next    = len_reg;
        act_next    = act_reg;
        tx_vld_next = tx_vld_reg;
        rx_vld_next = rx_vld_reg;
        acc_next    = acc_reg;
        sv_next     = sv_reg;
        use_tx_next = use_tx_reg;
        rd_next     = rd_reg;
        tx_ok_next  = tx_ok_reg;
        rx_ok_next  = rx_ok_reg;
        result_next = result_reg;
        tx_we       = 1'b0;
        rx_we       = 1'b0;

        if (cmd.capture)
        begin
            item_next = in_data;
        end
        if (cfg_valid)
        begin
            dummy_next = cfg_data;
        end

        if (cmd.exec)
        begin
            acc_next    = 1'b0;
            sv_next     = 1'b0;
            use_tx_next = 1'b0;
            rd_next     = 1'b0;
            tx_ok_next  = tx_vld_reg[tx_raddr];
            rx_ok_next  = rx_vld_reg[rx_raddr];
            unique case (mode_t'(item_reg.mode))
                MODE_LOAD_TX:
                begin
                    if (bidx_ok)
                    begin
                        tx_we = 1'b1;
                        tx_vld_next[tx_waddr] = 1'b1;
                    end
                end
                MODE_READ_RX:
                begin
                    rd_next = bidx_ok;
                end
                MODE_START_WR, MODE_START_RD, MODE_START_WRRD:
                begin
                    if (!busy && count_ok)
                    begin
                        acc_next    = 1'b1;
                        sv_next     = 1'b1;
                        use_tx_next = (mode_t'(item_reg.mode) != MODE_START_RD);
                        idx_next    = IW'(1);
                        len_next    = IW'(item_reg.byte_count);
                        act_next    = act_reg | sel_bit;
                        unique case (mode_t'(item_reg.mode))
                            MODE_START_WR: status_next = XS_TX_BUSY;
                            MODE_START_RD: status_next = XS_RX_BUSY;
                            default:       status_next = XS_TXRX_BUSY;
                        endcase
                    end
                end
                MODE_BYTE_DONE:
                begin
                    if ((status_reg == XS_RX_BUSY || status_reg == XS_TXRX_BUSY)
                        && idx_reg != '0)
                    begin
                        rx_we = 1'b1;
                        rx_vld_next[rx_waddr] = 1'b1;
                    end
                    if (busy)
                    begin
                        if (idx_reg < len_reg)
                        begin
                            sv_next     = 1'b1;
                            use_tx_next = (status_reg != XS_RX_BUSY);
                            idx_next    = idx_reg + IW'(1);
                        end
                        else
                        begin
                            unique case (status_reg)
                                XS_TX_BUSY: status_next = XS_TX_DONE;
                                XS_RX_BUSY: status_next = XS_RX_DONE;
                                default:    status_next = XS_TXRX_DONE;
                            endcase
                        end
                    end
                end
                MODE_CLEAR_IDLE:
                begin
                    if (is_done)
                    begin
                        status_next = XS_IDLE;
                        acc_next    = 1'b1;
                    end
                end
                MODE_DESELECT:
                begin
                    act_next = act_reg & ~(act_reg & (~act_reg + 4'd1));
                end
            endcase
        end

        if (cmd.fetch)
        begin
            result_next.accepted      = acc_reg;
            result_next.status        = status_reg;
            result_next.shift_valid   = sv_reg;
            result_next.shift_byte    = shift_byte;
            result_next.slave_enables = act_reg;
            result_next.read_data     = (rd_reg && rx_ok_reg) ? rx_rdata : 8'd0;
        end
    end

    always_comb
    begin
        priority if (!sv_reg)
        begin
            shift_byte = 8'd0;
        end
        else if (!use_tx_reg)
        begin
            shift_byte = dummy_reg;
        end
        else
        begin
            shift_byte = tx_ok_reg ? tx_rdata : 8'd0;
        end
    end

    assign out_data = result_reg;

    `ASSERT_CLK(a_busy_index, !busy || (idx_reg != '0 && idx_reg <= len_reg),
                "transfer index outside the active length")
    `ASSERT_CLK(a_slave_mask, (act_reg & ~SLAVE_MASK) == 4'd0,
                "slave enabled beyond the slave count")
    `ASSERT_NEXT(a_idle_stable, !cmd.exec, status_reg == $past(status_reg),
                 "transfer status changed outside execution")

endmodule

### rtl/core/spi_master_buffered_transfer.sv
`timescale 1ns / 1ps
// Channel   Handshake                 Payload
// in        in_valid / in_ready       in_data   (smbt_pkg::in_item_t)
// out       out_valid / out_ready     out_data  (smbt_pkg::out_item_t)
// cfg       cfg_valid / cfg_ready     cfg_data  (dummy byte)
//
// With out_ready held high, each item passes through accept, execute, fetch and result.
// The fetch cycle is the registered read of the transmit and receive buffer RAMs.
// in_ready is high only while no item is in flight; cfg_ready is always high.
// A stalled result holds the block until the result transfer completes.
// Reset is asynchronous; per-entry valid bits make both buffers read as zero
// right after reset, with no clearing pass.

module spi_master_buffered_transfer #(
    parameter int BUF_DEPTH   = 64,
    parameter int SLAVE_COUNT = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  smbt_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output smbt_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [7:0]          cfg_data
);

    import smbt_pkg::*;

    ctrl_cmd_t cmd;

    assign cfg_ready = 1'b1;

    smbt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    smbt_datapath #(
        .BUF_DEPTH   (BUF_DEPTH),
        .SLAVE_COUNT (SLAVE_COUNT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .out_data  (out_data)
    );

endmodule
